FILE: rtl/tasp_pkg.sv
// Shared types and constants for the three-axis step pulse controller.
`timescale 1ns / 1ps
`default_nettype none

package tasp_pkg;

  localparam int POSITION_BITS = 16;
  localparam int AXIS_COUNT    = 3;
  localparam int FIELD_BITS    = 16;
  localparam int APB_DATA_BITS = 32;
  localparam int APB_ADDR_BITS = 3;

  typedef logic [POSITION_BITS-1:0] pos_t;
  typedef logic [FIELD_BITS-1:0]    field_t;
  typedef logic [AXIS_COUNT-1:0]    axis_mask_t;

  typedef enum logic [2:0] {
    OP_TICK         = 3'd0,
    OP_JOG          = 3'd1,
    OP_SET_TARGET   = 3'd2,
    OP_LIMIT_HIT    = 3'd3,
    OP_CLEAR_LIMIT  = 3'd4
  } op_t;

  typedef enum logic {
    REG_X_TRAVEL_MAX = 1'b0,
    REG_Y_TRAVEL_MAX = 1'b1
  } cfg_reg_t;

  // One command to one axis; at most one of the strobes is high.
  typedef struct packed {
    logic   tick;
    logic   jog;
    logic   set_target;
    logic   limit_hit;
    logic   clear_limit;
    pos_t   amount;
    logic   fwd;
    logic   clamp_en;
    field_t travel_max;
  } axis_cmd_t;

  // Axis state after the current word has been applied.
  typedef struct packed {
    pos_t pos;
    logic step;
    logic dir;
    logic moving;
    logic limit;
  } axis_stat_t;

endpackage : tasp_pkg

`default_nettype wire

FILE: rtl/three_axis_step_pulse_controller.sv
// Top level of the three-axis step/direction pulse controller.
//
// Usage: each word on the in_ channel is either a timer tick or a command
// (jog, set target, limit hit, clear limit) for the axis in in_axis_sel.
// Every word produces exactly one result word on the out_ channel with the
// step, direction, moving and limit pins of all axes, the position of the
// addressed axis and a no-limit flag, all taken after the word is applied.
// A word accepted at the input is captured in the input register; it is
// applied to the axis state once the result register is free or drained,
// at the same edge at which out_valid rises. One word per cycle is
// sustained while out_stall is low.
// While out_stall holds a result, one more word may enter the input
// register; after that in_stall is raised until the result is taken.
// Reset clears all positions and targets, sets every direction forward,
// disables ticks and loads both travel limits with all ones. The user must
// write the APB registers only while no word is in flight; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module three_axis_step_pulse_controller
  import tasp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_op,
  input  wire logic [1:0]               in_axis_sel,
  input  wire logic [FIELD_BITS-1:0]    in_amount,
  input  wire logic                     in_jog_forward,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [AXIS_COUNT-1:0]         out_step_pins,
  output logic [AXIS_COUNT-1:0]         out_dir_pins,
  output logic [AXIS_COUNT-1:0]         out_moving_mask,
  output logic [AXIS_COUNT-1:0]         out_limit_mask,
  output logic [FIELD_BITS-1:0]         out_sel_position,
  output logic                          out_no_limit,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready
);

  field_t x_travel_max;
  field_t y_travel_max;

  logic       s1_valid_r, s1_valid_nxt;
  logic [2:0] s1_op_r;
  logic [1:0] s1_sel_r;
  field_t     s1_amount_r;
  logic       s1_fwd_r;

  logic       out_valid_r, out_valid_nxt;
  axis_mask_t out_step_r, out_dir_r, out_mov_r, out_lim_r;
  field_t     out_pos_r;
  logic       out_no_lim_r;

  logic       tick_en_r, tick_en_nxt;
  logic       advance;
  logic       s1_fire;
  logic       in_fire;
  logic       sel_ok;
  op_t        op_c;

  axis_cmd_t  cmd [AXIS_COUNT];
  axis_stat_t stat [AXIS_COUNT];

  axis_mask_t step_c, dir_c, mov_c, lim_c;
  field_t     pos_c;

  tasp_cfg_regs u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .x_travel_max (x_travel_max),
    .y_travel_max (y_travel_max)
  );

  // The input register moves on whenever the result register is free or drained.
  assign advance  = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;
  assign in_fire  = in_valid && !in_stall;

  assign op_c   = op_t'(s1_op_r);
  assign sel_ok = 32'(s1_sel_r) < AXIS_COUNT;

  always_comb begin
    tick_en_nxt = tick_en_r;
    if (s1_fire && sel_ok) begin
      case (op_c)
        OP_JOG, OP_SET_TARGET: tick_en_nxt = 1'b1;
        OP_LIMIT_HIT:          tick_en_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int a = 0; a < AXIS_COUNT; a++) begin
      cmd[a].tick        = 1'b0;
      cmd[a].jog         = 1'b0;
      cmd[a].set_target  = 1'b0;
      cmd[a].limit_hit   = 1'b0;
      cmd[a].clear_limit = 1'b0;
      cmd[a].amount      = POSITION_BITS'(s1_amount_r);
      cmd[a].fwd         = s1_fwd_r;
      cmd[a].clamp_en    = (a == 0) || (a == 1);
      cmd[a].travel_max  = (a == 0) ? x_travel_max : y_travel_max;
      if (s1_fire) begin
        case (op_c)
          OP_TICK:        cmd[a].tick        = tick_en_r;
          OP_JOG:         cmd[a].jog         = (32'(s1_sel_r) == a);
          OP_SET_TARGET:  cmd[a].set_target  = (32'(s1_sel_r) == a);
          OP_LIMIT_HIT:   cmd[a].limit_hit   = (32'(s1_sel_r) == a);
          OP_CLEAR_LIMIT: cmd[a].clear_limit = (32'(s1_sel_r) == a);
          default: ;
        endcase
      end
    end
  end

  for (genvar g = 0; g < AXIS_COUNT; g++) begin : g_axis
    tasp_axis u_axis (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd_i  (cmd[g]),
      .stat_o (stat[g])
    );
  end

  always_comb begin
    pos_c = '0;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      step_c[a] = stat[a].step;
      dir_c[a]  = stat[a].dir;
      mov_c[a]  = stat[a].moving;
      lim_c[a]  = stat[a].limit;
      if (32'(s1_sel_r) == a) begin
        pos_c = FIELD_BITS'(stat[a].pos);
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tick_en_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      tick_en_r   <= tick_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r     <= in_op;
      s1_sel_r    <= in_axis_sel;
      s1_amount_r <= in_amount;
      s1_fwd_r    <= in_jog_forward;
    end
    if (s1_fire) begin
      out_step_r   <= step_c;
      out_dir_r    <= dir_c;
      out_mov_r    <= mov_c;
      out_lim_r    <= lim_c;
      out_pos_r    <= sel_ok ? pos_c : '0;
      out_no_lim_r <= (lim_c == '0);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_step_pins    = out_step_r;
  assign out_dir_pins     = out_dir_r;
  assign out_moving_mask  = out_mov_r;
  assign out_limit_mask   = out_lim_r;
  assign out_sel_position = out_pos_r;
  assign out_no_limit     = out_no_lim_r;

  // The input register is only held back while a full result register is stalled.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_no_limit == (out_limit_mask == '0)))
    else $error("no_limit disagrees with limit mask");

  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && sel_ok && (op_c == OP_LIMIT_HIT)) |=> (!tick_en_r && out_valid))
    else $error("limit hit did not halt ticks");

  assert property (@(posedge clk) disable iff (!rst_n)
    !s1_fire |=> $stable(tick_en_r))
    else $error("tick enable changed without a word");

endmodule : three_axis_step_pulse_controller

`default_nettype wire

FILE: rtl/tasp_cfg_regs.sv
// APB register file holding the travel limits of the first two axes.
`timescale 1ns / 1ps
`default_nettype none

module tasp_cfg_regs
  import tasp_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_BITS-1:0] paddr,
  input  wire logic [APB_DATA_BITS-1:0] pwdata,
  output logic      [APB_DATA_BITS-1:0] prdata,
  output logic                          pready,
  output field_t                        x_travel_max,
  output field_t                        y_travel_max
);

  field_t   x_max_r, x_max_nxt;
  field_t   y_max_r, y_max_nxt;
  cfg_reg_t reg_sel;
  logic     wr_en;

  assign reg_sel = cfg_reg_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    x_max_nxt = x_max_r;
    y_max_nxt = y_max_r;
    if (wr_en) begin
      case (reg_sel)
        REG_X_TRAVEL_MAX: x_max_nxt = pwdata[FIELD_BITS-1:0];
        REG_Y_TRAVEL_MAX: y_max_nxt = pwdata[FIELD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_X_TRAVEL_MAX: prdata = APB_DATA_BITS'(x_max_r);
      REG_Y_TRAVEL_MAX: prdata = APB_DATA_BITS'(y_max_r);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_max_r <= '1;
      y_max_r <= '1;
    end else begin
      x_max_r <= x_max_nxt;
      y_max_r <= y_max_nxt;
    end
  end

  assign x_travel_max = x_max_r;
  assign y_travel_max = y_max_r;

endmodule : tasp_cfg_regs

`default_nettype wire

FILE: rtl/tasp_axis.sv
// State and update logic of one axis: position, target, direction and step pin.
`timescale 1ns / 1ps
`default_nettype none

module tasp_axis
  import tasp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire axis_cmd_t cmd_i,
  output axis_stat_t stat_o
);

  pos_t pos_r, pos_nxt;
  pos_t tgt_r, tgt_nxt;
  logic mov_r, mov_nxt;
  logic fwd_r, fwd_nxt;
  logic tog_r, tog_nxt;
  logic step_r, step_nxt;
  logic lim_r, lim_nxt;
  pos_t jog_sum;
  pos_t jog_tgt;

  // The jog target wraps first and, where clamping is enabled, is then held at or below the travel limit.
  always_comb begin
    jog_sum = cmd_i.fwd ? pos_r + cmd_i.amount : pos_r - cmd_i.amount;
    if (cmd_i.clamp_en && (32'(jog_sum) > 32'(cmd_i.travel_max))) begin
      jog_tgt = POSITION_BITS'(cmd_i.travel_max);
    end else begin
      jog_tgt = jog_sum;
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    tgt_nxt  = tgt_r;
    mov_nxt  = mov_r;
    fwd_nxt  = fwd_r;
    tog_nxt  = tog_r;
    step_nxt = step_r;
    lim_nxt  = lim_r;
    if (cmd_i.tick) begin
      if (pos_r == tgt_r) begin
        mov_nxt  = 1'b0;
        step_nxt = 1'b0;
      end
      if (mov_nxt) begin
        step_nxt = tog_r;
        tog_nxt  = ~tog_r;
        pos_nxt  = fwd_r ? pos_r + pos_t'(1) : pos_r - pos_t'(1);
      end
    end else if (cmd_i.jog) begin
      fwd_nxt = cmd_i.fwd;
      tgt_nxt = jog_tgt;
      mov_nxt = 1'b1;
    end else if (cmd_i.set_target) begin
      tgt_nxt = cmd_i.amount;
      fwd_nxt = cmd_i.amount > pos_r;
      mov_nxt = 1'b1;
    end else if (cmd_i.limit_hit) begin
      lim_nxt = 1'b1;
      mov_nxt = 1'b0;
      pos_nxt = '0;
    end else if (cmd_i.clear_limit) begin
      lim_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      tgt_r  <= '0;
      mov_r  <= 1'b0;
      fwd_r  <= 1'b1;
      tog_r  <= 1'b0;
      step_r <= 1'b0;
      lim_r  <= 1'b0;
    end else begin
      pos_r  <= pos_nxt;
      tgt_r  <= tgt_nxt;
      mov_r  <= mov_nxt;
      fwd_r  <= fwd_nxt;
      tog_r  <= tog_nxt;
      step_r <= step_nxt;
      lim_r  <= lim_nxt;
    end
  end

  assign stat_o.pos    = pos_nxt;
  assign stat_o.step   = step_nxt;
  assign stat_o.dir    = fwd_nxt;
  assign stat_o.moving = mov_nxt;
  assign stat_o.limit  = lim_nxt;

endmodule : tasp_axis

`default_nettype wire
